// ===== hw/rtl/ptc_pkg.sv =====
`default_nettype none

package ptc_pkg;

   // Frame position width; the reel holds at most 2**FRAME_WIDTH frames.
   localparam int FRAME_WIDTH = 16;
   localparam int LIM_WIDTH   = FRAME_WIDTH + 1;
   localparam int BIT_WIDTH   = $clog2(FRAME_WIDTH);
   localparam int unsigned FRAME_CAP = 1 << FRAME_WIDTH;

   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;

   localparam logic REG_FRAME_COUNT = 1'b0;
   localparam logic REG_SOURCE_FPS  = 1'b1;

   localparam logic [15:0] FRAME_COUNT_RESET = 16'd1024;
   localparam logic [5:0]  SOURCE_FPS_RESET  = 6'd30;

   localparam logic [2:0] MODE_PLAY    = 3'd0;
   localparam logic [2:0] MODE_PAUSE   = 3'd1;
   localparam logic [2:0] MODE_STEP    = 3'd2;
   localparam logic [2:0] MODE_REVERSE = 3'd3;
   localparam logic [2:0] MODE_FORWARD = 3'd4;

   localparam logic [3:0] SPEED_NONE = 4'd0;
   localparam logic [3:0] SPEED_SLOW = 4'd2;
   localparam logic [3:0] SPEED_MID  = 4'd4;
   localparam logic [3:0] SPEED_FAST = 4'd8;

   localparam logic [7:0] HOLD_MAX  = 8'd255;
   localparam logic [7:0] HOLD_FAST = 8'd60;
   localparam logic [7:0] HOLD_MID  = 8'd30;
   localparam logic [7:0] HOLD_TAP  = 8'd1;

   // Bit positions of the buttons in the packed button vector.
   localparam int B_START = 0;
   localparam int B_A     = 1;
   localparam int B_L     = 2;
   localparam int B_R     = 3;
   localparam int B_LEFT  = 4;
   localparam int B_RIGHT = 5;

   typedef struct packed {
      logic btn_right;
      logic btn_left;
      logic btn_r;
      logic btn_l;
      logic btn_a;
      logic btn_start;
   } req_type;

   typedef struct packed {
      logic [15:0] frame_index;
      logic [2:0]  transport_mode;
      logic [3:0]  speed;
      logic        jumped;
      logic        wrapped;
      logic        changed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] frame_count;
      logic [5:0]  source_fps;
   } cfg_type;

   // Seek distances already reduced modulo the frame limit.
   typedef struct packed {
      logic [FRAME_WIDTH-1:0] fps;
      logic [FRAME_WIDTH-1:0] one;
      logic [FRAME_WIDTH-1:0] two;
      logic [FRAME_WIDTH-1:0] four;
      logic [FRAME_WIDTH-1:0] eight;
   } res_type;

   typedef struct packed {
      logic                   valid;
      logic [FRAME_WIDTH-1:0] value;
   } cur_wr_type;

   // A frame count of zero, or one beyond the position range, means the full range.
   function automatic logic [LIM_WIDTH-1:0] frame_limit(input logic [15:0] fc);
      logic [16:0] fcx;
      fcx = {1'b0, fc};
      if (fc == 16'd0 || fcx > 17'(FRAME_CAP)) begin
         frame_limit = LIM_WIDTH'(FRAME_CAP);
      end else begin
         frame_limit = LIM_WIDTH'(fc);
      end
   endfunction

   // Moves a reduced position by a reduced distance, wrapping into [0, lim).
   function automatic logic [FRAME_WIDTH-1:0] seek_wrap(
      input logic [FRAME_WIDTH-1:0] pos,
      input logic [FRAME_WIDTH-1:0] amt,
      input logic                   back,
      input logic [LIM_WIDTH-1:0]   lim);
      logic [LIM_WIDTH-1:0] sum;
      logic [LIM_WIDTH-1:0] res;
      sum = {1'b0, pos} + {1'b0, amt};
      if (back) begin
         if (pos >= amt) begin
            res = {1'b0, pos} - {1'b0, amt};
         end else begin
            res = {1'b0, pos} + lim - {1'b0, amt};
         end
      end else begin
         if (sum >= lim) begin
            res = sum - lim;
         end else begin
            res = sum;
         end
      end
      seek_wrap = res[FRAME_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptc_csr.sv =====
`default_nettype none

module ptc_csr import ptc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [DATA_WIDTH-1:0] pwdata,
   output logic      [DATA_WIDTH-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg,
   output logic                       wr
);

   logic [15:0] frame_count_ff;
   logic [5:0]  source_fps_ff;
   logic        sel;

   assign sel    = paddr[2];
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         source_fps_ff  <= SOURCE_FPS_RESET;
      end else if (wr) begin
         case (sel)
            REG_FRAME_COUNT: begin
               frame_count_ff <= pwdata[15:0];
            end
            REG_SOURCE_FPS: begin
               source_fps_ff <= pwdata[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_FRAME_COUNT: prdata = DATA_WIDTH'(frame_count_ff);
         REG_SOURCE_FPS:  prdata = DATA_WIDTH'(source_fps_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.frame_count = frame_count_ff;
   assign cfg.source_fps  = source_fps_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptc_reducer.sv =====
`default_nettype none

// Restoring remainder unit, one bit per cycle, run over each seek distance
// and the current position after a register write.
module ptc_reducer import ptc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [LIM_WIDTH-1:0]   lim,
   input  wire logic [5:0]             source_fps,
   input  wire logic [FRAME_WIDTH-1:0] frame,
   output logic                        busy,
   output res_type                     res,
   output cur_wr_type                  cur_wr
);

   localparam logic [2:0] OP_CUR   = 3'd0;
   localparam logic [2:0] OP_FPS   = 3'd1;
   localparam logic [2:0] OP_ONE   = 3'd2;
   localparam logic [2:0] OP_TWO   = 3'd3;
   localparam logic [2:0] OP_FOUR  = 3'd4;
   localparam logic [2:0] OP_EIGHT = 3'd5;
   localparam logic [BIT_WIDTH-1:0] BIT_TOP = BIT_WIDTH'(FRAME_WIDTH - 1);

   logic                   busy_ff, busy_in;
   logic [2:0]             op_ff, op_in;
   logic [BIT_WIDTH-1:0]   bit_ff, bit_in;
   logic [FRAME_WIDTH-1:0] rem_ff, rem_in;
   res_type                res_ff, res_in;
   logic [FRAME_WIDTH-1:0] operand;
   logic [LIM_WIDTH-1:0]   shifted;
   logic [LIM_WIDTH-1:0]   trial;
   logic [FRAME_WIDTH-1:0] rem_next;
   logic                   last_bit;

   always_comb begin
      case (op_ff)
         OP_CUR:   operand = frame;
         OP_FPS:   operand = FRAME_WIDTH'(source_fps);
         OP_ONE:   operand = FRAME_WIDTH'(1);
         OP_TWO:   operand = FRAME_WIDTH'(2);
         OP_FOUR:  operand = FRAME_WIDTH'(4);
         OP_EIGHT: operand = FRAME_WIDTH'(8);
         default:  operand = '0;
      endcase
   end

   assign shifted  = {rem_ff, operand[bit_ff]};
   assign trial    = shifted - lim;
   assign rem_next = (shifted >= lim) ? trial[FRAME_WIDTH-1:0] : shifted[FRAME_WIDTH-1:0];
   assign last_bit = (bit_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in   = OP_CUR;
         bit_in  = BIT_TOP;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_next;
         if (last_bit) begin
            case (op_ff)
               OP_FPS:   res_in.fps   = rem_next;
               OP_ONE:   res_in.one   = rem_next;
               OP_TWO:   res_in.two   = rem_next;
               OP_FOUR:  res_in.four  = rem_next;
               OP_EIGHT: res_in.eight = rem_next;
               default: begin
               end
            endcase
            rem_in = '0;
            bit_in = BIT_TOP;
            if (op_ff == OP_EIGHT) begin
               busy_in = 1'b0;
            end else begin
               op_in = op_ff + 3'd1;
            end
         end else begin
            bit_in = bit_ff - BIT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         op_ff        <= OP_CUR;
         bit_ff       <= BIT_TOP;
         rem_ff       <= '0;
         res_ff.fps   <= FRAME_WIDTH'(SOURCE_FPS_RESET);
         res_ff.one   <= FRAME_WIDTH'(1);
         res_ff.two   <= FRAME_WIDTH'(2);
         res_ff.four  <= FRAME_WIDTH'(4);
         res_ff.eight <= FRAME_WIDTH'(8);
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         bit_ff  <= bit_in;
         rem_ff  <= rem_in;
         res_ff  <= res_in;
      end
   end

   assign busy         = busy_ff;
   assign res          = res_ff;
   assign cur_wr.valid = busy_ff && !start && last_bit && (op_ff == OP_CUR);
   assign cur_wr.value = rem_next;

   // The partial remainder is always already reduced.
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, rem_ff} < lim))
      else $error("partial remainder not below frame limit");

endmodule

`default_nettype wire

// ===== hw/rtl/ptc_step.sv =====
`default_nettype none

// Transport state and the single-pass update for one playback period.
module ptc_step import ptc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  req_type                     req,
   input  wire logic [LIM_WIDTH-1:0]   lim,
   input  res_type                     res,
   input  cur_wr_type                  cur_wr,
   output rsp_type                     rsp,
   output logic [FRAME_WIDTH-1:0]      frame
);

   logic [5:0]             prev_ff, prev_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   resume_ff, resume_in;
   logic [2:0]             mode_ff, mode_in;
   logic [3:0]             speed_ff, speed_in;
   logic [FRAME_WIDTH-1:0] frame_ff, frame_in;
   logic [FRAME_WIDTH-1:0] cmod_ff, cmod_in;

   logic [5:0]             pad;
   logic [5:0]             pressed;
   logic [2:0]             mode_a;
   logic [3:0]             speed_a;
   logic [FRAME_WIDTH-1:0] pos_a, frame_a;
   logic [7:0]             hold_up;
   logic [3:0]             rate;
   logic [FRAME_WIDTH-1:0] amount;
   logic                   left, right;
   logic [LIM_WIDTH-1:0]   next;
   logic                   chg, jmp, wrp;

   always_comb begin
      pad     = req;
      pressed = pad & ~prev_ff;
      left    = pad[B_LEFT];
      right   = pad[B_RIGHT];

      // Button presses, highest priority first.
      mode_a  = mode_ff;
      speed_a = speed_ff;
      pos_a   = cmod_ff;
      frame_a = frame_ff;
      chg     = 1'b0;
      jmp     = 1'b0;
      if (pressed[B_START]) begin
         mode_a  = (mode_ff == MODE_PLAY) ? MODE_PAUSE : MODE_PLAY;
         speed_a = SPEED_NONE;
         chg     = 1'b1;
      end else if (pressed[B_A]) begin
         mode_a  = MODE_PLAY;
         speed_a = SPEED_NONE;
         chg     = 1'b1;
      end else if (pressed[B_L] || pressed[B_R]) begin
         pos_a   = seek_wrap(cmod_ff, res.one, pressed[B_L], lim);
         frame_a = pos_a;
         mode_a  = MODE_STEP;
         speed_a = SPEED_NONE;
         chg     = 1'b1;
         jmp     = 1'b1;
      end

      // Direction hold.
      hold_up = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 8'd1;
      if (hold_up >= HOLD_FAST) begin
         rate   = SPEED_FAST;
         amount = res.eight;
      end else if (hold_up >= HOLD_MID) begin
         rate   = SPEED_MID;
         amount = res.four;
      end else begin
         rate   = SPEED_SLOW;
         amount = res.two;
      end
      if (hold_up == HOLD_TAP) begin
         amount = res.fps;
      end

      hold_in   = hold_ff;
      resume_in = resume_ff;
      mode_in   = mode_a;
      speed_in  = speed_a;
      cmod_in   = pos_a;
      frame_in  = frame_a;
      if (left && right) begin
         hold_in = 8'd0;
      end else if (left || right) begin
         if (hold_ff == 8'd0) begin
            resume_in = (mode_a == MODE_PLAY);
         end
         hold_in  = hold_up;
         cmod_in  = seek_wrap(pos_a, amount, left, lim);
         frame_in = cmod_in;
         mode_in  = left ? MODE_REVERSE : MODE_FORWARD;
         speed_in = rate;
         chg      = 1'b1;
         jmp      = 1'b1;
      end else begin
         if (hold_ff != 8'd0) begin
            mode_in  = resume_ff ? MODE_PLAY : MODE_PAUSE;
            speed_in = SPEED_NONE;
            chg      = 1'b1;
         end
         hold_in = 8'd0;
      end

      // Play advance; the raw position may sit beyond a lowered frame count.
      next = {1'b0, frame_in} + LIM_WIDTH'(1);
      wrp  = 1'b0;
      if (mode_in == MODE_PLAY) begin
         if (next >= lim) begin
            frame_in = '0;
            wrp      = 1'b1;
         end else begin
            frame_in = next[FRAME_WIDTH-1:0];
         end
         cmod_in = frame_in;
      end

      prev_in = pad;

      rsp.frame_index    = 16'(frame_in);
      rsp.transport_mode = mode_in;
      rsp.speed          = speed_in;
      rsp.jumped         = jmp;
      rsp.wrapped        = wrp;
      rsp.changed        = chg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         hold_ff   <= '0;
         resume_ff <= 1'b0;
         mode_ff   <= MODE_PLAY;
         speed_ff  <= SPEED_NONE;
         frame_ff  <= '0;
         cmod_ff   <= '0;
      end else if (fire) begin
         prev_ff   <= prev_in;
         hold_ff   <= hold_in;
         resume_ff <= resume_in;
         mode_ff   <= mode_in;
         speed_ff  <= speed_in;
         frame_ff  <= frame_in;
         cmod_ff   <= cmod_in;
      end else if (cur_wr.valid) begin
         cmod_ff <= cur_wr.value;
      end
   end

   assign frame = frame_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/playback_transport_controller.sv =====
`default_nettype none

// Channel    Direction  Handshake               Contents
// req_       in         req_valid / req_ready   six button levels, one playback period
// rsp_       out        rsp_valid / rsp_ready   frame, mode, speed and event flags
// csr_       in/out     APB, pready always high frame_count at 0x0, source_fps at 0x4
//
// A request is taken into an input register and worked in one pass into the result register, so one
// request per clock is sustained while the result side is ready and the remainder unit is idle.
// The input register takes a new request while a finished result still waits.
// Reset is synchronous and active high; the reduced seek distances need no pass.
// After each register write a bit-serial remainder unit runs, one bit per cycle over
// six operands, and req_ready is low while it runs. A stall on the result side holds
// the result register and a held request; frame and mode move only with a result.
module playback_transport_controller import ptc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_btn_start,
   input  wire logic                  req_btn_a,
   input  wire logic                  req_btn_l,
   input  wire logic                  req_btn_r,
   input  wire logic                  req_btn_left,
   input  wire logic                  req_btn_right,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_frame_index,
   output logic [2:0]                 rsp_transport_mode,
   output logic [3:0]                 rsp_speed,
   output logic                       rsp_jumped,
   output logic                       rsp_wrapped,
   output logic                       rsp_changed,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [DATA_WIDTH-1:0] csr_pwdata,
   output logic      [DATA_WIDTH-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type                cfg;
   logic                   cfg_wr;
   logic [LIM_WIDTH-1:0]   lim;
   logic                   busy;
   res_type                res;
   cur_wr_type             cur_wr;
   logic [FRAME_WIDTH-1:0] frame;
   rsp_type                step_rsp;

   logic                   in_valid_ff, in_valid_in;
   req_type                req_ff, req_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   fire;
   logic                   take;

   ptc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .wr      (cfg_wr)
   );

   // The limit is the frame count with zero read as the full position range.
   assign lim = frame_limit(cfg.frame_count);

   ptc_reducer u_reducer (
      .clock      (clock),
      .reset      (reset),
      .start      (cfg_wr),
      .lim        (lim),
      .source_fps (cfg.source_fps),
      .frame      (frame),
      .busy       (busy),
      .res        (res),
      .cur_wr     (cur_wr)
   );

   ptc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (req_ff),
      .lim    (lim),
      .res    (res),
      .cur_wr (cur_wr),
      .rsp    (step_rsp),
      .frame  (frame)
   );

   // A held request is worked whenever the result register is free or being emptied and
   // the remainder unit is idle; the input register refills in the same cycle.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready) && !busy;
   assign req_ready = !busy && (!in_valid_ff || fire);
   assign take      = req_valid && req_ready;

   always_comb begin
      req_in.btn_start = req_btn_start;
      req_in.btn_a     = req_btn_a;
      req_in.btn_l     = req_btn_l;
      req_in.btn_r     = req_btn_r;
      req_in.btn_left  = req_btn_left;
      req_in.btn_right = req_btn_right;

      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_in = step_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_index    = rsp_ff.frame_index;
   assign rsp_transport_mode = rsp_ff.transport_mode;
   assign rsp_speed          = rsp_ff.speed;
   assign rsp_jumped         = rsp_ff.jumped;
   assign rsp_wrapped        = rsp_ff.wrapped;
   assign rsp_changed        = rsp_ff.changed;

   // A request that could not be worked is still held in the next cycle.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("held request lost without a result");

   // A seek or step is always reported as a change.
   a_jump_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jumped |-> rsp_changed)
      else $error("jump reported without change");

   // A wrap only comes from the play advance and lands on frame zero.
   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wrapped |-> (rsp_frame_index == 16'd0)
                                   && (rsp_transport_mode == MODE_PLAY))
      else $error("wrap without play at frame zero");

   // Speed is none or one of the seek rates.
   a_speed_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed == SPEED_NONE) || (rsp_speed == SPEED_SLOW)
                    || (rsp_speed == SPEED_MID) || (rsp_speed == SPEED_FAST))
      else $error("speed outside the seek rates");

endmodule

`default_nettype wire

// ===== verif/playback_transport_controller_test.sv =====
`default_nettype none

module playback_transport_controller_test import ptc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Button masks in the packed order of req_type, start in bit zero.
   localparam logic [5:0] PAD_NONE  = 6'd0;
   localparam logic [5:0] PAD_START = 6'(1 << B_START);
   localparam logic [5:0] PAD_A     = 6'(1 << B_A);
   localparam logic [5:0] PAD_L     = 6'(1 << B_L);
   localparam logic [5:0] PAD_R     = 6'(1 << B_R);
   localparam logic [5:0] PAD_LEFT  = 6'(1 << B_LEFT);
   localparam logic [5:0] PAD_RIGHT = 6'(1 << B_RIGHT);
   localparam logic [5:0] PAD_ALL   = 6'h3F;

   localparam int HOLDOFF_CYCLES = 200;
   localparam int CYCLE_LIMIT    = 250000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_btn_start = 1'b0;
   logic        req_btn_a     = 1'b0;
   logic        req_btn_l     = 1'b0;
   logic        req_btn_r     = 1'b0;
   logic        req_btn_left  = 1'b0;
   logic        req_btn_right = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_frame_index;
   logic [2:0]  rsp_transport_mode;
   logic [3:0]  rsp_speed;
   logic        rsp_jumped;
   logic        rsp_wrapped;
   logic        rsp_changed;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic                  csr_pready;

   playback_transport_controller u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_btn_start      (req_btn_start),
      .req_btn_a          (req_btn_a),
      .req_btn_l          (req_btn_l),
      .req_btn_r          (req_btn_r),
      .req_btn_left       (req_btn_left),
      .req_btn_right      (req_btn_right),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_transport_mode (rsp_transport_mode),
      .rsp_speed          (rsp_speed),
      .rsp_jumped         (rsp_jumped),
      .rsp_wrapped        (rsp_wrapped),
      .rsp_changed        (rsp_changed),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Our own copy of the transport state and of the two registers. It is
   // advanced once for every request that the block accepts.
   logic [5:0]  last_pad    = '0;
   logic [7:0]  hold_len    = '0;
   logic        resume_flag = 1'b0;
   logic [2:0]  mode_now    = MODE_PLAY;
   logic [3:0]  speed_now   = SPEED_NONE;
   logic [15:0] frame_pos   = '0;
   logic [15:0] reel_frames = FRAME_COUNT_RESET;
   logic [5:0]  tap_frames  = SOURCE_FPS_RESET;

   // Results of accepted requests that have not yet come out, oldest first.
   rsp_type queued_periods[$];

   int fault_count   = 0;
   int results_seen  = 0;
   int periods_sent  = 0;
   int unsigned cycle_count = 0;

   // Sender burst shaping: gap_max of zero means requests back to back.
   int gap_max    = 6;
   int burst_left = 0;

   // The receiver's long hold-off is asked for by bumping holdoff_asks; the
   // receiver process notices the change and counts the stretch itself.
   int holdoff_asks  = 0;
   int holdoff_taken = 0;
   int holdoff_left  = 0;
   int pattern_age   = 0;
   logic [7:0] stall_mask    = 8'hFF;
   logic [2:0] pattern_phase = '0;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on %s at result %0d: got %0d, want %0d", what, results_seen, got,
               want);
      fault_count++;
   endtask

   // A zero frame count stands for the whole 16-bit position range.
   function automatic int reel_limit();
      return (reel_frames == 16'd0) ? int'(FRAME_CAP) : int'(reel_frames);
   endfunction

   // Moves the position by a signed distance and wraps it into the reel. A
   // position left beyond a lowered frame count is reduced first.
   function automatic void move_frame(input int stride);
      int lim;
      int pos;
      lim = reel_limit();
      pos = (int'(frame_pos) % lim) + (stride % lim);
      if (pos < 0) pos += lim;
      if (pos >= lim) pos -= lim;
      frame_pos = pos[15:0];
   endfunction

   // Works out what one playback period does to the transport, and returns
   // the result that the block should report for it.
   function automatic rsp_type advance_transport(input req_type pad);
      logic [5:0] now_pad;
      logic [5:0] fresh;
      logic [3:0] rate;
      int         stride;
      int         next_pos;
      rsp_type    r;
      now_pad  = pad;
      fresh    = now_pad & ~last_pad;
      last_pad = now_pad;
      r        = '0;

      // Only the highest-priority new press acts.
      if (fresh[B_START]) begin
         mode_now  = (mode_now == MODE_PLAY) ? MODE_PAUSE : MODE_PLAY;
         speed_now = SPEED_NONE;
         r.changed = 1'b1;
      end else if (fresh[B_A]) begin
         mode_now  = MODE_PLAY;
         speed_now = SPEED_NONE;
         r.changed = 1'b1;
      end else if (fresh[B_L] || fresh[B_R]) begin
         move_frame(fresh[B_L] ? -1 : 1);
         mode_now  = MODE_STEP;
         speed_now = SPEED_NONE;
         r.changed = 1'b1;
         r.jumped  = 1'b1;
      end

      if (now_pad[B_LEFT] && now_pad[B_RIGHT]) begin
         // Both directions cancel the hold without restoring the mode.
         hold_len = '0;
      end else if (now_pad[B_LEFT] || now_pad[B_RIGHT]) begin
         if (hold_len == 8'd0) resume_flag = (mode_now == MODE_PLAY);
         if (hold_len != HOLD_MAX) hold_len++;
         rate = (hold_len >= HOLD_FAST) ? SPEED_FAST :
                (hold_len >= HOLD_MID)  ? SPEED_MID  : SPEED_SLOW;
         // The first period of a hold jumps a whole second of source frames.
         stride = (hold_len == HOLD_TAP) ? int'(tap_frames) : int'(rate);
         if (now_pad[B_LEFT]) stride = -stride;
         move_frame(stride);
         mode_now  = now_pad[B_LEFT] ? MODE_REVERSE : MODE_FORWARD;
         speed_now = rate;
         r.changed = 1'b1;
         r.jumped  = 1'b1;
      end else begin
         if (hold_len != 8'd0) begin
            mode_now  = resume_flag ? MODE_PLAY : MODE_PAUSE;
            speed_now = SPEED_NONE;
            r.changed = 1'b1;
         end
         hold_len = '0;
      end

      if (mode_now == MODE_PLAY) begin
         next_pos = int'(frame_pos) + 1;
         if (next_pos >= reel_limit()) begin
            next_pos  = 0;
            r.wrapped = 1'b1;
         end
         frame_pos = next_pos[15:0];
      end

      r.frame_index    = frame_pos;
      r.transport_mode = mode_now;
      r.speed          = speed_now;
      return r;
   endfunction

   // Offers one request and waits for it to be taken. Between bursts the
   // sender drops valid for a random gap, unless gap_max is zero.
   task automatic send_period(input logic [5:0] bits);
      req_type pad;
      int      gap;
      pad = req_type'(bits);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max != 0) gap = $urandom_range(1, gap_max);
      end
      burst_left--;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_btn_start <= pad.btn_start;
      req_btn_a     <= pad.btn_a;
      req_btn_l     <= pad.btn_l;
      req_btn_r     <= pad.btn_r;
      req_btn_left  <= pad.btn_left;
      req_btn_right <= pad.btn_right;
      do @(posedge clock); while (!req_ready);
      queued_periods.push_back(advance_transport(pad));
      periods_sent++;
   endtask

   // Stops offering requests until every outstanding result has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (queued_periods.size() != 0) @(posedge clock);
   endtask

   // One APB transfer, followed by a return to idle so that two transfers never
   // run back to back.
   task automatic csr_cycle(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register, reads it back and updates our copy. Callers make
   // sure that the block is idle first.
   task automatic set_register(input logic idx, input logic [15:0] value);
      logic [31:0] seen;
      logic [31:0] want;
      csr_cycle(1'b1, idx, 32'(value), seen);
      csr_cycle(1'b0, idx, '0, seen);
      if (idx == REG_FRAME_COUNT) begin
         reel_frames = value;
         want        = 32'(value);
      end else begin
         tap_frames = value[5:0];
         want       = 32'(value[5:0]);
      end
      if (seen != want) report_mismatch("register readback", seen, want);
   endtask

   // Random button sessions. Most are well-formed holds and taps, so that
   // the hold counter climbs through its rates; the rest is noise.
   task automatic play_session(input int count);
      int         target;
      int         kind;
      int         span;
      logic [5:0] dir;
      logic [5:0] extra;
      target = periods_sent + count;
      while (periods_sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            dir  = $urandom_range(0, 1) ? PAD_LEFT : PAD_RIGHT;
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) :
                                                 $urandom_range(1, 12);
            for (int k = 0; k < span; k++) begin
               extra = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 15)) : PAD_NONE;
               // Now and then the direction swaps without a release.
               if ($urandom_range(0, 40) == 0) dir = dir ^ (PAD_LEFT | PAD_RIGHT);
               send_period(dir | extra);
            end
            send_period(PAD_NONE);
         end else if (kind < 7) begin
            send_period(6'($urandom_range(1, 15)));
            send_period(PAD_NONE);
         end else if (kind == 7) begin
            span = $urandom_range(1, 4);
            for (int k = 0; k < span; k++) begin
               send_period(PAD_LEFT | PAD_RIGHT | 6'($urandom_range(0, 15)));
            end
         end else begin
            span = $urandom_range(1, 6);
            for (int k = 0; k < span; k++) send_period(6'($urandom_range(0, 63)));
         end
      end
   endtask

   // The registers must come out of reset at their documented values.
   task automatic test_reset_values();
      logic [31:0] seen;
      csr_cycle(1'b0, REG_FRAME_COUNT, '0, seen);
      if (seen != 32'(FRAME_COUNT_RESET)) begin
         report_mismatch("frame_count reset", seen, FRAME_COUNT_RESET);
      end
      csr_cycle(1'b0, REG_SOURCE_FPS, '0, seen);
      if (seen != 32'(SOURCE_FPS_RESET)) report_mismatch("source_fps reset", seen,
                                                         SOURCE_FPS_RESET);
   endtask

   // Hand-picked periods: each button but R on its own, presses that compete for
   // priority, taps, a direction swap mid-hold and both directions at once.
   task automatic test_button_priority();
      logic [5:0] script[$];
      script = '{PAD_NONE, PAD_START, PAD_NONE, PAD_START, PAD_START | PAD_A, PAD_NONE,
                 PAD_A, PAD_L, PAD_L | PAD_R, PAD_NONE, PAD_L | PAD_R, PAD_NONE, PAD_A,
                 PAD_ALL, PAD_NONE, PAD_LEFT, PAD_LEFT, PAD_RIGHT, PAD_NONE, PAD_A,
                 PAD_RIGHT | PAD_R, PAD_RIGHT | PAD_LEFT, PAD_RIGHT, PAD_NONE, PAD_START};
      gap_max = 3;
      foreach (script[i]) send_period(script[i]);
   endtask

   // Long holds through both rate thresholds, then past the saturation of
   // the hold counter, on the full position range with the largest tap.
   task automatic test_hold_ramp();
      wait_all_results();
      set_register(REG_FRAME_COUNT, 16'd0);
      set_register(REG_SOURCE_FPS, 16'd63);
      gap_max = 4;
      for (int k = 0; k < 70; k++) send_period(PAD_RIGHT);
      send_period(PAD_NONE);
      send_period(PAD_START);
      for (int k = 0; k < 262; k++) send_period(PAD_LEFT);
      send_period(PAD_NONE);
   endtask

   // A run of register settings, extremes included: the whole range, the
   // largest count, a one-frame reel, and a tap seek of zero frames.
   task automatic test_register_extremes();
      logic [15:0] counts[5];
      logic [15:0] taps[5];
      counts = '{16'd0, 16'd65535, 16'd64, 16'd1, 16'd3};
      taps   = '{16'd63, 16'd1, 16'd0, 16'd60, 16'd7};
      gap_max = 6;
      foreach (counts[i]) begin
         wait_all_results();
         set_register(REG_FRAME_COUNT, counts[i]);
         set_register(REG_SOURCE_FPS, taps[i]);
         play_session(20);
      end
   endtask

   // Parks the position near the top of the full range, then shrinks the
   // reel under it, so that a play advance, a step and a seek each start
   // from a frame beyond the count.
   task automatic test_reel_shrink();
      wait_all_results();
      set_register(REG_SOURCE_FPS, 16'd63);
      for (int variant = 0; variant < 3; variant++) begin
         wait_all_results();
         set_register(REG_FRAME_COUNT, 16'd64);
         send_period(PAD_A);
         send_period(PAD_NONE);
         wait_all_results();
         set_register(REG_FRAME_COUNT, 16'd0);
         send_period(PAD_LEFT);
         send_period(PAD_LEFT);
         send_period(PAD_NONE);
         wait_all_results();
         set_register(REG_FRAME_COUNT, 16'd100);
         case (variant)
            0: send_period(PAD_NONE);
            1: send_period(PAD_R);
            default: send_period(PAD_RIGHT);
         endcase
         send_period(PAD_NONE);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so both internal registers fill and req_ready must drop.
   task automatic test_backpressure();
      gap_max = 0;
      holdoff_asks++;
      for (int k = 0; k < 12; k++) send_period(6'($urandom_range(0, 63)));
      wait_all_results();
   endtask

   // The bulk of the run: random sessions, mostly under random settings, with one
   // phase where the sender never idles.
   task automatic test_random_sessions();
      for (int phase = 0; phase < 4; phase++) begin
         wait_all_results();
         if (phase == 3) begin
            set_register(REG_FRAME_COUNT, FRAME_COUNT_RESET);
            set_register(REG_SOURCE_FPS, 16'(SOURCE_FPS_RESET));
         end else begin
            set_register(REG_FRAME_COUNT, 16'($urandom_range(64, 65535)));
            set_register(REG_SOURCE_FPS, 16'($urandom_range(1, 60)));
         end
         gap_max = (phase == 1) ? 0 : $urandom_range(2, 8);
         play_session(100);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_button_priority();
      test_hold_ramp();
      test_register_extremes();
      test_reel_shrink();
      test_backpressure();
      test_random_sessions();
      wait_all_results();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("playback_transport_controller_test passed");
      end else begin
         $display("playback_transport_controller_test failed");
      end
      $finish;
   end

   // Receiver: a long hold-off when asked for, otherwise a rotating stall
   // mask that is redrawn now and then, sometimes with no stalls at all.
   always @(posedge clock) begin
      if (holdoff_asks != holdoff_taken) begin
         holdoff_taken = holdoff_asks;
         holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = 48;
            stall_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         end
         pattern_age--;
         rsp_ready <= stall_mask[pattern_phase];
         pattern_phase++;
      end
   end

   // Each result taken from the block is matched against the oldest
   // outstanding period, field by field.
   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.frame_index    = rsp_frame_index;
         got.transport_mode = rsp_transport_mode;
         got.speed          = rsp_speed;
         got.jumped         = rsp_jumped;
         got.wrapped        = rsp_wrapped;
         got.changed        = rsp_changed;
         if (queued_periods.size() == 0) begin
            report_mismatch("result with no request outstanding", got.frame_index, 0);
         end else begin
            want = queued_periods.pop_front();
            if (got.frame_index != want.frame_index) begin
               report_mismatch("frame_index", got.frame_index, want.frame_index);
            end
            if (got.transport_mode != want.transport_mode) begin
               report_mismatch("transport_mode", got.transport_mode, want.transport_mode);
            end
            if (got.speed != want.speed) report_mismatch("speed", got.speed, want.speed);
            if (got.jumped != want.jumped) report_mismatch("jumped", got.jumped, want.jumped);
            if (got.wrapped != want.wrapped) begin
               report_mismatch("wrapped", got.wrapped, want.wrapped);
            end
            if (got.changed != want.changed) begin
               report_mismatch("changed", got.changed, want.changed);
            end
         end
         results_seen++;
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("playback_transport_controller_test failed");
         $finish;
      end
   end

endmodule

`default_nettype wire

// ===== playback_transport_controller.f =====
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_csr.sv
hw/rtl/ptc_reducer.sv
hw/rtl/ptc_step.sv
hw/rtl/playback_transport_controller.sv
verif/playback_transport_controller_test.sv
